// ===== hdl/slpa_pkg.sv =====
// Package: shared types, widths and status codes of the slot pool allocator.
`timescale 1ns / 1ps
`default_nettype none

package slpa_pkg;

    // Default pool size.
    localparam int SLOTS_DEFAULT = 256;

    // Fixed field widths of the request and response.
    localparam int SLOT_W  = 8;
    localparam int COUNT_W = 9;

    typedef logic [1:0] t_status;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [COUNT_W-1:0] t_count;

    // Request operations.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Response status codes.
    localparam t_status ST_ALLOCATED = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_FREED     = 2'd2;
    localparam t_status ST_IGNORED   = 2'd3;

endpackage

`default_nettype wire

// ===== hdl/slpa_ifs.sv =====
// Interfaces: the request and response channels of the slot pool allocator.
`timescale 1ns / 1ps
`default_nettype none

interface slpa_req_if;
    import slpa_pkg::*;

    logic  valid;
    logic  ready;
    logic  operation;
    t_slot slot;

    modport source (output valid, output operation, output slot, input ready);
    modport sink   (input valid, input operation, input slot, output ready);
endinterface

interface slpa_rsp_if;
    import slpa_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_slot   granted_slot;
    t_count  live_count;

    modport source (output valid, output status, output granted_slot, output live_count,
                    input ready);
    modport sink   (input valid, input status, input granted_slot, input live_count,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/slpa_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module slpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read-first: a read at the address being written returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/slot_pool_free_list_allocator.sv =====
// Top level: slot pool allocator built on a singly linked free list.
//
// Requests arrive on i_req (operation, slot) and each gives exactly one
// response on o_rsp (status, granted_slot, live_count). An allocate pops the
// head of the free list; a free of a live slot pushes it back onto the head.
// Freeing a dead slot, or allocating from an empty pool, changes nothing.
//
// A request is captured in an input register and decided there; its
// response is loaded into the output register once that is free, which
// raises o_rsp.valid. One request is taken every cycle while o_rsp.ready
// is high; the figure is set by the head pointer and the link it needs,
// which is fetched ahead from the link RAM read port or the push bypass.
//
// After reset the list holds every slot in ascending order and none is alive.
// No clearing pass is needed: a fill count marks the slots ever handed out, and
// an entry at or above it reads with its reset link and as dead, so requests
// are accepted from the first cycle after reset. When the receiver holds
// o_rsp.ready low the response stays put, the request in the input register
// waits, and i_req.ready falls once both are occupied.
`timescale 1ns / 1ps
`default_nettype none

module slot_pool_free_list_allocator #(
    parameter int SLOTS = slpa_pkg::SLOTS_DEFAULT
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    slpa_req_if.sink  i_req,
    slpa_rsp_if.source o_rsp
);
    import slpa_pkg::*;

    // Address width of the per-slot stores, and width of a link, head pointer
    // or count, which must also hold the end mark SLOTS itself.
    localparam int AW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);
    // Common widths used when the 8-bit slot field meets the wider pool.
    localparam int XW = (AW > SLOT_W) ? AW : SLOT_W;
    localparam int ZW = (LW > SLOT_W) ? LW : SLOT_W;

    // Handshake and input register.
    logic          r_v1;
    logic          r_op;
    t_slot         r_slot;
    logic          w_adv;
    logic          w_acc;

    // Allocator state.
    logic [LW-1:0] r_head;
    logic [LW-1:0] r_fill;
    logic [LW-1:0] r_live;
    logic [LW-1:0] n_head;
    logic [LW-1:0] n_fill;
    logic [LW-1:0] n_live;

    // Read bypasses for a write that lands on the address being read.
    logic          r_lbyp_v;
    logic [LW-1:0] r_lbyp_d;
    logic          r_abyp_v;
    logic          r_abyp_d;

    // Response register.
    logic          r_ov;
    t_status       r_status;
    t_slot         r_granted;

    // RAM ports.
    logic          l_we;
    logic [AW-1:0] l_wa;
    logic [LW-1:0] l_wd;
    logic [AW-1:0] l_ra;
    logic [LW-1:0] l_q;
    logic          a_we;
    logic [AW-1:0] a_wa;
    logic          a_wd;
    logic [AW-1:0] a_ra;
    logic          a_q;

    // Decision of the request held in the input register.
    logic [AW-1:0] w_slot_a;
    logic [ZW-1:0] w_slot_z;
    logic [ZW-1:0] w_fill_z;
    logic          w_head_fresh;
    logic          w_list_empty;
    logic [LW-1:0] w_head_link;
    logic          w_slot_live;
    t_status       d_status;
    t_slot         d_granted;
    logic [LW-1:0] d_head;
    logic [LW-1:0] d_fill;
    logic [LW-1:0] d_live;
    logic          d_lwe;
    logic          d_awe;
    logic          d_awd;

    assign w_adv         = r_v1 && (!r_ov || o_rsp.ready);
    assign i_req.ready   = !r_v1 || w_adv;
    assign w_acc         = i_req.valid && i_req.ready;

    assign w_slot_a      = AW'(XW'(r_slot));
    assign w_slot_z      = ZW'(r_slot);
    assign w_fill_z      = ZW'(r_fill);

    // A head at or above the fill mark has never been handed out, so its link
    // is still the reset value: the next slot up.
    assign w_head_fresh  = (r_head >= r_fill);
    assign w_list_empty  = (r_head == LW'(SLOTS));
    assign w_head_link   = w_head_fresh ? (r_head + LW'(1)) :
                           (r_lbyp_v ? r_lbyp_d : l_q);
    // Slots at or above the fill mark are dead; this also rejects a slot index
    // beyond a pool smaller than the slot field.
    assign w_slot_live   = (w_slot_z < w_fill_z) && (r_abyp_v ? r_abyp_d : a_q);

    always_comb begin
        d_status  = ST_IGNORED;
        d_granted = '0;
        d_head    = r_head;
        d_fill    = r_fill;
        d_live    = r_live;
        d_lwe     = 1'b0;
        d_awe     = 1'b0;
        d_awd     = 1'b0;
        a_wa      = w_slot_a;
        if (r_op == OP_ALLOC) begin
            if (w_list_empty) begin
                d_status = ST_FULL;
            end else begin
                d_status  = ST_ALLOCATED;
                d_granted = SLOT_W'(r_head);
                d_head    = w_head_link;
                if (w_head_fresh) begin
                    d_fill = r_fill + LW'(1);
                end
                d_live    = r_live + LW'(1);
                d_awe     = 1'b1;
                d_awd     = 1'b1;
                a_wa      = AW'(r_head);
            end
        end else if (w_slot_live) begin
            d_status = ST_FREED;
            d_head   = LW'(w_slot_z);
            if (r_live != '0) begin
                d_live = r_live - LW'(1);
            end
            d_lwe    = 1'b1;
            d_awe    = 1'b1;
        end
    end

    assign n_head = w_adv ? d_head : r_head;
    assign n_fill = w_adv ? d_fill : r_fill;
    assign n_live = w_adv ? d_live : r_live;

    // A push writes the old head as the link of the freed slot.
    assign l_we = w_adv && d_lwe && i_rst_n;
    assign l_wa = w_slot_a;
    assign l_wd = r_head;
    // The link of the next head is fetched every cycle.
    assign l_ra = AW'(n_head);

    assign a_we = w_adv && d_awe && i_rst_n;
    assign a_wd = d_awd;
    // The alive bit is fetched as the request enters the input register and
    // refetched while it waits there.
    assign a_ra = w_acc ? AW'(XW'(i_req.slot)) : w_slot_a;

    slpa_ram #(
        .WIDTH (LW),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_wa),
        .i_wdata (l_wd),
        .i_raddr (l_ra),
        .o_rdata (l_q)
    );

    slpa_ram #(
        .WIDTH (1),
        .DEPTH (SLOTS)
    ) u_alive_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_wa),
        .i_wdata (a_wd),
        .i_raddr (a_ra),
        .o_rdata (a_q)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_ov     <= 1'b0;
            r_head   <= '0;
            r_fill   <= '0;
            r_live   <= '0;
            r_lbyp_v <= 1'b0;
            r_abyp_v <= 1'b0;
        end else begin
            if (w_acc) begin
                r_v1 <= 1'b1;
            end else if (w_adv) begin
                r_v1 <= 1'b0;
            end
            if (w_adv) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
            r_head   <= n_head;
            r_fill   <= n_fill;
            r_live   <= n_live;
            r_lbyp_v <= l_we && (l_wa == l_ra);
            r_abyp_v <= a_we && (a_wa == a_ra);
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_op   <= i_req.operation;
            r_slot <= i_req.slot;
        end
        if (w_adv) begin
            r_status  <= d_status;
            r_granted <= d_granted;
        end
        r_lbyp_d <= l_wd;
        r_abyp_d <= a_wd;
    end

    // The live count changes only when a new response is loaded, so it always
    // matches the response being shown.
    assign o_rsp.valid        = r_ov;
    assign o_rsp.status       = r_status;
    assign o_rsp.granted_slot = r_granted;
    assign o_rsp.live_count   = COUNT_W'(r_live);

`ifndef SYNTHESIS
    // Every live slot has been handed out at some time.
    a_live_within_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= r_fill)
        else $error("live count exceeds fill mark");

    // An empty free list means the whole pool is alive.
    a_empty_means_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_list_empty |-> (r_live == LW'(SLOTS)) && (r_fill == LW'(SLOTS)))
        else $error("free list empty while slots remain dead");

    // A granted allocation raises the live count by one.
    a_alloc_counts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (r_op == OP_ALLOC) && !w_list_empty) |=>
            (r_live == $past(r_live) + LW'(1)))
        else $error("allocation did not raise the live count");

    // A response is loaded only when the previous one has gone.
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_rsp.ready) |=> $stable(r_status) && $stable(r_granted))
        else $error("stalled response overwritten");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench of the slot pool allocator with a free-list predictor.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import slpa_pkg::*;

    // The scoreboard keeps its own copy of the free list. It is told about each
    // request when the request is accepted. It works out the response that the
    // request must give and checks the responses in the order they arrive.
    class slot_pool_scoreboard;
        typedef struct packed {
            t_status status;
            t_slot   granted;
            t_count  live;
        } t_slot_grant;

        localparam int POOL = SLOTS_DEFAULT;

        // The free-list image. A link value of POOL or more marks the end of the list.
        logic [COUNT_W-1:0] link_of[POOL];
        bit                 alive_of[POOL];
        logic [COUNT_W-1:0] head_slot;
        t_count             live_total;

        t_slot_grant expected_grants[$];
        int mismatches;
        int responses_seen;
        int status_seen[4];
        int peak_live;

        function new();
            for (int i = 0; i < POOL; i++) begin
                link_of[i]  = COUNT_W'(i + 1);
                alive_of[i] = 1'b0;
            end
            head_slot  = '0;
            live_total = '0;
            mismatches = 0;
            responses_seen = 0;
            peak_live = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int pending();
            return expected_grants.size();
        endfunction

        // Returns a live slot, starting the search at a random place, or -1 if none is live.
        function int pick_live_slot();
            int start;
            int idx;
            start = $urandom_range(0, POOL - 1);
            for (int k = 0; k < POOL; k++) begin
                idx = (start + k) % POOL;
                if (alive_of[idx]) return idx;
            end
            return -1;
        endfunction

        // Applies one accepted request to the free-list image and queues its response.
        function void note_request(logic op, t_slot slot);
            t_slot_grant exp_grant;
            int idx;
            exp_grant.granted = '0;
            if (op == OP_ALLOC) begin
                if (head_slot >= POOL) begin
                    exp_grant.status = ST_FULL;
                end else begin
                    idx = int'(head_slot);
                    head_slot = link_of[idx];
                    if (head_slot > POOL) head_slot = COUNT_W'(POOL);
                    alive_of[idx] = 1'b1;
                    live_total = live_total + 1'b1;
                    exp_grant.status  = ST_ALLOCATED;
                    exp_grant.granted = t_slot'(idx);
                end
            end else if (!alive_of[slot]) begin
                exp_grant.status = ST_IGNORED;
            end else begin
                alive_of[slot] = 1'b0;
                link_of[slot]  = head_slot;
                head_slot      = COUNT_W'(slot);
                if (live_total > 0) live_total = live_total - 1'b1;
                exp_grant.status = ST_FREED;
            end
            exp_grant.live = live_total;
            if (int'(live_total) > peak_live) peak_live = int'(live_total);
            expected_grants.push_back(exp_grant);
        endfunction

        function void check_response(t_status status, t_slot granted, t_count live);
            t_slot_grant exp_grant;
            responses_seen++;
            status_seen[status]++;
            if (expected_grants.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: response with nothing expected: status %0d slot %0d live %0d",
                             status, granted, live);
                return;
            end
            exp_grant = expected_grants.pop_front();
            if (status !== exp_grant.status || granted !== exp_grant.granted
                    || live !== exp_grant.live) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: response %0d: expected status %0d slot %0d live %0d",
                             responses_seen, exp_grant.status, exp_grant.granted,
                             exp_grant.live);
                    $display("       got status %0d slot %0d live %0d",
                             status, granted, live);
                end
            end
        endfunction
    endclass

    // Generous bound on the whole run, far beyond the slowest correct run with
    // every gap and every stall at its longest.
    localparam int CYCLE_LIMIT = 200000;
    // Latency from acceptance to response, with some margin, for the final wait.
    localparam int SETTLE_CYCLES = 10;

    logic i_clk;
    logic i_rst_n;

    slpa_req_if req_if ();
    slpa_rsp_if rsp_if ();

    slot_pool_free_list_allocator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    slot_pool_scoreboard sb = new();

    int  cycle_count = 0;
    int  requests_sent = 0;
    // Random idling on both sides is only allowed while this is set; the last
    // phase of the run clears it.
    bit  idle_en = 1'b1;
    // Set by the stimulus to ask the response side for one long hold-off.
    bit  long_hold_req = 1'b0;
    int  hold_left = 0;
    int  rsp_burst_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle counter and watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d responses outstanding.",
                     cycle_count, sb.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Response side. A long hold-off, when asked for, is counted down here;
    // otherwise ready drops in short random bursts. Idling is only allowed in
    // two windows out of every three so that calm stretches occur as well.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = 60;
            rsp_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end else if (rsp_burst_left > 0) begin
            rsp_burst_left--;
            rsp_if.ready <= 1'b0;
        end else if (idle_en && ((cycle_count / 64) % 3 != 0)
                     && $urandom_range(0, 4) == 0) begin
            rsp_burst_left = $urandom_range(0, 2);
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Every accepted response is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_response(rsp_if.status, rsp_if.granted_slot, rsp_if.live_count);
    end

    // Offers one request and waits until it is accepted. It is called at a
    // rising edge and returns at the edge of acceptance, so valid is only
    // ever lowered for a gap and never lowered and raised within one step.
    task automatic send_request(input logic op, input t_slot slot);
        int gap;
        if (idle_en && (requests_sent % 100) < 70 && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.slot      <= slot;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(op, slot);
        requests_sent++;
    endtask

    // Stops offering requests until every expected response has come back.
    task automatic wait_for_responses();
        req_if.valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    // A phase of random requests. Allocations take the share given in percent;
    // most frees name a live slot so that the list is really exercised, and
    // the rest name any slot, which mostly hits dead ones.
    task automatic random_phase(input int count, input int alloc_pct);
        int live_slot;
        t_slot slot;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < alloc_pct) begin
                send_request(OP_ALLOC, t_slot'($urandom_range(0, 255)));
            end else begin
                live_slot = sb.pick_live_slot();
                if (live_slot >= 0 && $urandom_range(0, 99) < 85)
                    slot = t_slot'(live_slot);
                else
                    slot = t_slot'($urandom_range(0, 255));
                send_request(OP_FREE, slot);
            end
        end
    endtask

    initial begin
        req_if.valid     <= 1'b0;
        req_if.operation <= OP_ALLOC;
        req_if.slot      <= '0;
        i_rst_n          <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Allocations from the fresh list come out in ascending
        // order; a second free of the same slot and a free of a slot never
        // handed out are both ignored; freed slots come back in reverse order
        // of freeing, since each free pushes onto the head.
        send_request(OP_ALLOC, 8'hFF);
        send_request(OP_ALLOC, 8'h00);
        send_request(OP_ALLOC, 8'hAA);
        send_request(OP_FREE, 8'd1);
        send_request(OP_FREE, 8'd1);
        send_request(OP_FREE, 8'd255);
        send_request(OP_FREE, 8'd0);
        send_request(OP_ALLOC, 8'h55);
        send_request(OP_ALLOC, 8'h00);
        send_request(OP_ALLOC, 8'hFF);
        send_request(OP_FREE, 8'd2);
        send_request(OP_FREE, 8'd3);
        send_request(OP_FREE, 8'd0);
        send_request(OP_FREE, 8'd1);
        send_request(OP_FREE, 8'd128);
        send_request(OP_ALLOC, 8'h00);
        send_request(OP_ALLOC, 8'h00);
        send_request(OP_ALLOC, 8'h00);
        send_request(OP_ALLOC, 8'h00);
        send_request(OP_ALLOC, 8'h00);
        send_request(OP_FREE, 8'd4);
        send_request(OP_FREE, 8'd127);

        // Let the pipeline empty before the random part starts.
        wait_for_responses();

        // Balanced traffic around a low fill level.
        random_phase(150, 50);

        // Fill phase. It opens with a long hold-off on the response side while
        // requests keep coming, so the block backs up and stalls its input.
        // Allocations dominate, so the pool runs full and keeps reporting it.
        long_hold_req = 1'b1;
        random_phase(320, 95);
        wait_for_responses();

        // Drain phase: mostly frees, taking the pool back down towards empty.
        random_phase(300, 10);

        // Final stretch without any idling on either side.
        idle_en = 1'b0;
        random_phase(60, 50);

        wait_for_responses();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d responses to %0d requests in %0d cycles, peak %0d live slots.",
                 sb.responses_seen, requests_sent, cycle_count, sb.peak_live);
        $display("Statuses seen: %0d allocated, %0d pool full, %0d freed, %0d ignored frees.",
                 sb.status_seen[ST_ALLOCATED], sb.status_seen[ST_FULL],
                 sb.status_seen[ST_FREED], sb.status_seen[ST_IGNORED]);
        if (sb.pending() > 0)
            $display("ERROR: %0d expected responses never arrived.", sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches in total.", sb.mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
